[rtl/tmsw_pkg.sv]
// Package for the trimmed-mean sample window core.
// Field widths, parameter defaults and the shared ALU operation codes.
// No dependencies.
package tmsw_pkg;

    // Payload field widths
    localparam int SAMPLE_W     = 12;
    localparam int CHAN_IN_W    = 4;
    localparam int RES_CHAN_W   = 3;

    // Width of the trimmed mean (the mean fits a sample)
    localparam int QUO_W        = SAMPLE_W;

    // Default window size and channel count
    localparam int DEF_WINDOW   = 8;
    localparam int DEF_CHANNELS = 8;

    // Entries dropped from each window: one largest, one smallest
    localparam int TRIM_COUNT   = 2;

    // Shared adder operations
    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

endpackage

[rtl/trimmed_mean_sample_window_core.sv]
// Trimmed-mean moving average over per-channel windows of 12-bit samples. Each accepted
// sample is written into its channel's circular history (CHANNELS x WINDOW entries, one
// RAM), then the window is scanned one entry per cycle through a single shared adder that
// also trims the maximum and minimum; the division by WINDOW - 2 is one multiply by its
// scaled reciprocal. After a sample is accepted it is written, the window is scanned, the
// maximum and then the minimum are subtracted, the sum is multiplied by the reciprocal and
// the output register is loaded. s_ready stays low meanwhile and rises together with the
// result, so a new sample is only taken once the last result is in the output register. A
// finished result waits in an output register so the next sample can be taken while it is
// pending. Samples with a channel at or above CHANNELS are dropped with no result and the
// input stays open. After reset the history RAM is cleared one entry per cycle, all
// CHANNELS x WINDOW entries (64 by default), with s_ready low.
module trimmed_mean_sample_window_core
    import tmsw_pkg::*;
#(
    parameter int WINDOW   = DEF_WINDOW,
    parameter int CHANNELS = DEF_CHANNELS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [CHAN_IN_W-1:0]  s_channel,
    input  logic [SAMPLE_W-1:0]   s_sample,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [RES_CHAN_W-1:0] m_result_channel,
    output logic [SAMPLE_W-1:0]   m_average
);

    localparam int DEPTH     = CHANNELS * WINDOW;
    localparam int AW        = $clog2(DEPTH);
    localparam int POS_W     = $clog2(WINDOW);
    localparam int IDX_W     = $clog2(WINDOW + 1);
    localparam int CHAN_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SUM_W     = SAMPLE_W + $clog2(WINDOW);
    localparam int DIVISOR   = WINDOW - TRIM_COUNT;
    // Reciprocal scaled so that the product shifted right is the exact floor quotient
    localparam int DIV_SHIFT = SUM_W + $clog2(DIVISOR);
    localparam int RECIP_W   = SUM_W + 1;
    localparam int PROD_W    = SUM_W + RECIP_W;
    localparam longint RECIP = ((longint'(1) << DIV_SHIFT) + longint'(DIVISOR) - 1)
                               / longint'(DIVISOR);
    localparam logic [RECIP_W-1:0] RECIP_K = RECIP_W'(RECIP);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_SCAN,
        ST_TRIM_HI,
        ST_TRIM_LO,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t                state_reg, state_next;
    logic [AW-1:0]         clr_cnt_reg, clr_cnt_next;
    logic [CHAN_W-1:0]     chan_reg, chan_next;
    logic [RES_CHAN_W-1:0] res_chan_reg, res_chan_next;
    logic [SAMPLE_W-1:0]   sample_reg, sample_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic                  rd_vld_reg, rd_vld_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [SAMPLE_W-1:0]   hi_reg, hi_next;
    logic [SAMPLE_W-1:0]   lo_reg, lo_next;
    logic [QUO_W-1:0]      quo_reg, quo_next;
    logic                  m_valid_reg, m_valid_next;
    logic [RES_CHAN_W-1:0] m_chan_reg, m_chan_next;
    logic [SAMPLE_W-1:0]   m_avg_reg, m_avg_next;

    logic [POS_W-1:0]      pos_reg [CHANNELS];
    logic [POS_W-1:0]      cur_pos;
    logic [POS_W-1:0]      pos_wrap;

    logic [SAMPLE_W-1:0]   hist_mem [DEPTH];
    logic [SAMPLE_W-1:0]   rd_data_reg;
    logic [AW-1:0]         base_addr;
    logic [AW-1:0]         wr_addr;
    logic [AW-1:0]         rd_addr;
    logic [SAMPLE_W-1:0]   wr_data;
    logic                  mem_we;

    alu_op_t               alu_op;
    logic [SUM_W-1:0]      alu_a;
    logic [SUM_W-1:0]      alu_b;
    logic [SUM_W-1:0]      alu_res;
    logic                  alu_carry;
    logic [PROD_W-1:0]     prod;
    logic                  in_range;
    logic                  out_free;

    // Shared arithmetic unit
    tmsw_alu #(
        .WIDTH (SUM_W)
    ) u_alu (
        .op    (alu_op),
        .a     (alu_a),
        .b     (alu_b),
        .res   (alu_res),
        .carry (alu_carry)
    );

    // Window addressing and write pointer wrap
    assign base_addr = AW'(chan_reg) * AW'(WINDOW);
    assign cur_pos   = pos_reg[chan_reg];
    assign pos_wrap  = (cur_pos == POS_W'(WINDOW - 1)) ? '0 : cur_pos + 1'b1;
    assign rd_addr   = base_addr + AW'(idx_reg[POS_W-1:0]);
    assign wr_addr   = (state_reg == ST_CLEAR) ? clr_cnt_reg : base_addr + AW'(cur_pos);
    assign wr_data   = (state_reg == ST_CLEAR) ? '0 : sample_reg;
    assign mem_we    = (state_reg == ST_CLEAR) || (state_reg == ST_WRITE);

    assign in_range  = {1'b0, s_channel} < (CHAN_IN_W + 1)'(CHANNELS);
    assign out_free  = !m_valid_reg || m_ready;

    // Divide the trimmed sum by multiplying with the scaled reciprocal
    assign prod      = PROD_W'(sum_reg) * PROD_W'(RECIP_K);

    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_result_channel = m_chan_reg;
    assign m_average        = m_avg_reg;

    // History RAM: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            hist_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= hist_mem[rd_addr];
    end

    // Route operands to the shared adder
    always_comb begin
        alu_op = ALU_ADD;
        alu_a  = '0;
        alu_b  = '0;
        case (state_reg)
            ST_SCAN: begin
                alu_op = ALU_ADD;
                alu_a  = sum_reg;
                alu_b  = SUM_W'(rd_data_reg);
            end
            ST_TRIM_HI: begin
                alu_op = ALU_SUB;
                alu_a  = sum_reg;
                alu_b  = SUM_W'(hi_reg);
            end
            ST_TRIM_LO: begin
                alu_op = ALU_SUB;
                alu_a  = sum_reg;
                alu_b  = SUM_W'(lo_reg);
            end
            default: begin
                alu_op = ALU_ADD;
            end
        endcase
    end

    // Sequencer next-state logic
    always_comb begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        chan_next     = chan_reg;
        res_chan_next = res_chan_reg;
        sample_next   = sample_reg;
        idx_next      = idx_reg;
        rd_vld_next   = 1'b0;
        sum_next      = sum_reg;
        hi_next       = hi_reg;
        lo_next       = lo_reg;
        quo_next      = quo_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_chan_next   = m_chan_reg;
        m_avg_next    = m_avg_reg;

        case (state_reg)
            // Zero the history after reset
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            // Take a transfer; drop out-of-range channels
            ST_IDLE: begin
                if (s_valid) begin
                    chan_next     = s_channel[CHAN_W-1:0];
                    res_chan_next = s_channel[RES_CHAN_W-1:0];
                    sample_next   = s_sample;
                    if (in_range) begin
                        state_next = ST_WRITE;
                    end
                end
            end
            // Store the sample, advance the pointer, prime the scan
            ST_WRITE: begin
                idx_next   = '0;
                sum_next   = '0;
                hi_next    = '0;
                lo_next    = '1;
                state_next = ST_SCAN;
            end
            // Issue one read per cycle, fold in the data from the previous one
            ST_SCAN: begin
                if (idx_reg < IDX_W'(WINDOW)) begin
                    idx_next    = idx_reg + 1'b1;
                    rd_vld_next = 1'b1;
                end
                if (rd_vld_reg) begin
                    sum_next = alu_res;
                    if (rd_data_reg > hi_reg) begin
                        hi_next = rd_data_reg;
                    end
                    if (rd_data_reg < lo_reg) begin
                        lo_next = rd_data_reg;
                    end
                    if (idx_reg == IDX_W'(WINDOW)) begin
                        state_next = ST_TRIM_HI;
                    end
                end
            end
            ST_TRIM_HI: begin
                sum_next   = alu_res;
                state_next = ST_TRIM_LO;
            end
            // Remove the minimum
            ST_TRIM_LO: begin
                sum_next   = alu_res;
                state_next = ST_DIV;
            end
            // Keep the upper product bits as the quotient
            ST_DIV: begin
                quo_next   = QUO_W'(prod >> DIV_SHIFT);
                state_next = ST_DONE;
            end
            // Hold until the output register is free
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_chan_next  = res_chan_reg;
                    m_avg_next   = quo_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, control and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            idx_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                pos_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            idx_reg     <= idx_next;
            rd_vld_reg  <= rd_vld_next;
            m_valid_reg <= m_valid_next;
            if (state_reg == ST_WRITE) begin
                pos_reg[chan_reg] <= pos_wrap;
            end
        end
        chan_reg     <= chan_next;
        res_chan_reg <= res_chan_next;
        sample_reg   <= sample_next;
        sum_reg      <= sum_next;
        hi_reg       <= hi_next;
        lo_reg       <= lo_next;
        quo_reg      <= quo_next;
        m_chan_reg   <= m_chan_next;
        m_avg_reg    <= m_avg_next;
    end

endmodule

[rtl/tmsw_alu.sv]
// Shared adder/subtractor used for window accumulation and trimming.
// Depends on tmsw_pkg for the operation codes.
module tmsw_alu
    import tmsw_pkg::*;
#(
    parameter int WIDTH = 16
) (
    input  alu_op_t          op,
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    output logic [WIDTH-1:0] res,
    output logic             carry
);

    logic [WIDTH-1:0] b_eff;
    logic             cin;

    // Subtract as a + ~b + 1; carry out high means no borrow
    always_comb begin
        case (op)
            ALU_ADD: begin
                b_eff = b;
                cin   = 1'b0;
            end
            ALU_SUB: begin
                b_eff = ~b;
                cin   = 1'b1;
            end
            default: begin
                b_eff = b;
                cin   = 1'b0;
            end
        endcase
    end

    assign {carry, res} = {1'b0, a} + {1'b0, b_eff} + {{WIDTH{1'b0}}, cin};

endmodule

[rtl/tmsw_checker.sv]
// Port-level assertions for the trimmed-mean sample window core, bound to the top level.
// Depends on tmsw_pkg for field widths and defaults.
module tmsw_checker
    import tmsw_pkg::*;
#(
    parameter int CHANNELS = DEF_CHANNELS
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic [CHAN_IN_W-1:0]  s_channel,
    input logic [SAMPLE_W-1:0]   s_sample,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [RES_CHAN_W-1:0] m_result_channel,
    input logic [SAMPLE_W-1:0]   m_average
);

    logic in_range;

    assign in_range = {1'b0, s_channel} < (CHAN_IN_W + 1)'(CHANNELS);

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_channel) && $stable(m_average))
        else $error("result changed while stalled");

    // The history clear keeps the input closed right after reset
    a_clear_after_reset: assert property (@(posedge aclk)
        $past(!aresetn) |-> !s_ready)
        else $error("input open during history clear");

    // A transfer on a valid channel closes the input while it is worked on
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && in_range |=> !s_ready ##1 !s_ready)
        else $error("input reopened during window scan");

    // A new result only appears after a busy cycle
    a_result_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared without work");

    // A dropped channel leaves the input open
    a_drop_stays_open: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !in_range |=> s_ready)
        else $error("out-of-range channel was not dropped");

endmodule

bind trimmed_mean_sample_window_core tmsw_checker #(
    .CHANNELS (CHANNELS)
) u_tmsw_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .s_channel        (s_channel),
    .s_sample         (s_sample),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_result_channel (m_result_channel),
    .m_average        (m_average)
);
